// ----- hw/rtl/rpnh_pkg.sv -----
// Shared constants and types for the ray/polygon nearest-hit block.
`timescale 1ns / 1ps
package rpnh_pkg;
   localparam int COORD_BITS_DEF = 32;
   localparam int PARAM_BITS     = 32;
   localparam int T_FRAC         = 16;

   // control handed from the sequencer to the edge unit
   typedef struct packed {
      logic start;
      logic clear_best;
   } edge_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } edge_sts_type;
endpackage

// ----- hw/rtl/rpnh_if.sv -----
// Valid/ready stream interface carrying a packed payload.
`timescale 1ns / 1ps
interface rpnh_if #(parameter int WIDTH = 1) (input logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ray_polygon_nearest_hit_top.sv -----
// Top level: vertex sequencer, edge unit and result register.
`timescale 1ns / 1ps
// Each edge test runs six serial multiplies for the cross products and, unless it ends
// early, a restoring division for t (skipped if t saturates) and two serial multiplies
// for the hit point; a closing vertex also tests the edge back to the start vertex.
// Throughput: one vertex at a time; the next transfer waits until its edge tests end.
// Synchronous reset clears the vertex count and best hit.
module ray_polygon_nearest_hit_top #(
   parameter int COORD_BITS = rpnh_pkg::COORD_BITS_DEF
) (
   input logic clock,
   input logic reset,
   rpnh_if.sink   req,
   rpnh_if.source rsp
);
   import rpnh_pkg::*;
   localparam int CB = COORD_BITS;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_E1 = 4'b0010, S_E2 = 4'b0100, S_OUT = 4'b1000
   } seq_type;

   seq_type st_ff, st_in;
   logic signed [CB-1:0] ox_ff, oy_ff, ex_ff, ey_ff, vx_ff, vy_ff;
   logic signed [CB-1:0] sx_ff, sx_in, sy_ff, sy_in, px_ff, px_in, py_ff, py_in;
   logic [1:0] seen_ff, seen_in;
   logic last_ff;
   logic rv_ff, rv_in;
   logic [2*CB:0] rd_ff, rd_in;
   logic started_ff, started_in;

   edge_ctl_type ctl;
   edge_sts_type sts;
   logic bvalid;
   logic signed [CB-1:0] bx, by;
   logic signed [CB-1:0] ax, ay, bbx, bby;

   // payload order: origin x,y, end x,y, vertex x,y, first, last
   logic signed [CB-1:0] i_ox, i_oy, i_ex, i_ey, i_vx, i_vy;
   logic i_first, i_last;
   assign {i_ox, i_oy, i_ex, i_ey, i_vx, i_vy, i_first, i_last} = req.data;

   assign req.ready = (st_ff == S_IDLE);
   logic acc;
   assign acc = req.valid && req.ready;

   // edge endpoints: prev->vertex, then vertex->start on close
   always_comb begin
      if (st_ff == S_E2) begin
         ax = vx_ff; ay = vy_ff; bbx = sx_ff; bby = sy_ff;
      end else begin
         ax = px_ff; ay = py_ff; bbx = vx_ff; bby = vy_ff;
      end
   end

   always_comb begin
      st_in = st_ff; sx_in = sx_ff; sy_in = sy_ff; px_in = px_ff; py_in = py_ff;
      seen_in = seen_ff; rv_in = rv_ff; rd_in = rd_ff; started_in = 1'b0;
      ctl = '0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (st_ff)
         S_IDLE: if (acc) begin
            ctl.clear_best = i_first;
            seen_in = i_first ? 2'd0 : seen_ff;
            if (seen_in == 2'd0) begin
               sx_in = i_vx; sy_in = i_vy; seen_in = 2'd1;
               st_in = i_last ? S_OUT : S_IDLE;
            end else begin
               seen_in = 2'd2; st_in = S_E1; started_in = 1'b1;
            end
         end
         S_E1: begin
            ctl.start = started_ff;
            if (sts.done) begin
               px_in = vx_ff; py_in = vy_ff;
               if (last_ff) begin
                  st_in = S_E2; started_in = 1'b1;
               end else st_in = S_IDLE;
            end
         end
         S_E2: begin
            ctl.start = started_ff;
            if (sts.done) st_in = S_OUT;
         end
         S_OUT: if (!rv_ff) begin
            rv_in = 1'b1;
            rd_in = {bvalid, bvalid ? bx : '0, bvalid ? by : '0};
            ctl.clear_best = 1'b1; seen_in = 2'd0; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      if (st_ff == S_IDLE && acc) begin
         px_in = i_vx; py_in = i_vy;
         if (seen_in == 2'd2) begin px_in = px_ff; py_in = py_ff; end
      end
   end

   rpnh_edge #(.CB(CB)) u_edge (
      .clock, .reset, .ctl, .ox(ox_ff), .oy(oy_ff), .ex(ex_ff), .ey(ey_ff),
      .ax, .ay, .bx(bbx), .by(bby), .sts, .best_valid(bvalid),
      .best_x(bx), .best_y(by)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; seen_ff <= '0; rv_ff <= 1'b0; started_ff <= 1'b0;
         sx_ff <= '0; sy_ff <= '0; px_ff <= '0; py_ff <= '0;
      end else begin
         st_ff <= st_in; seen_ff <= seen_in; rv_ff <= rv_in; started_ff <= started_in;
         sx_ff <= sx_in; sy_ff <= sy_in; px_ff <= px_in; py_ff <= py_in;
      end
      if (acc) begin
         ox_ff <= i_ox; oy_ff <= i_oy; ex_ff <= i_ex; ey_ff <= i_ey;
         vx_ff <= i_vx; vy_ff <= i_vy; last_ff <= i_last;
      end
      rd_ff <= rd_in;
   end

   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;
   logic unused;
   assign unused = sts.busy;
endmodule

// ----- hw/rtl/rpnh_serial_mul.sv -----
// Signed shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module rpnh_serial_mul #(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic                done,
   output logic signed [AW+BW-1:0] prod
);
   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW + 1);
   logic [PW-1:0]  acc_ff, acc_in;
   logic [PW-1:0]  mcand_ff, mcand_in;
   logic [BW-1:0]  mplier_ff, mplier_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           run_ff, run_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff; mcand_in = mcand_ff; mplier_in = mplier_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = PW'(a);
         mplier_in = b;
         cnt_in    = '0;
         run_in    = 1'b1;
      end else if (run_ff) begin
         // last bit of b has negative weight
         if (mplier_ff[0]) begin
            if (cnt_ff == CW'(BW - 1)) acc_in = acc_ff - mcand_ff;
            else acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == CW'(BW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in; mcand_ff <= mcand_in; mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign prod = $signed(acc_ff);
endmodule

// ----- hw/rtl/rpnh_edge.sv -----
// Edge test: cross products, restoring division for t, hit point, best update.
`timescale 1ns / 1ps
module rpnh_edge #(
   parameter int CB = rpnh_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rpnh_pkg::edge_ctl_type  ctl,
   input  logic signed [CB-1:0]    ox, oy, ex, ey, ax, ay, bx, by,
   output rpnh_pkg::edge_sts_type  sts,
   output logic                    best_valid,
   output logic signed [CB-1:0]    best_x,
   output logic signed [CB-1:0]    best_y
);
   import rpnh_pkg::*;
   localparam int DW = CB + 1;          // differences
   localparam int PW = 2 * DW;          // products
   localparam int XW = PW + 1;          // cross products
   localparam int RW = XW + T_FRAC + 1; // division remainder
   localparam int QW = T_FRAC + 1;
   localparam int MW = PARAM_BITS + 1 + DW;
   localparam int QC = $clog2(PARAM_BITS + 1);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001, ST_M1 = 8'b00000010, ST_M2 = 8'b00000100,
      ST_CHK  = 8'b00001000, ST_DIV = 8'b00010000, ST_PX = 8'b00100000,
      ST_PY   = 8'b01000000, ST_DONE = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] ph_ff, ph_in;  // product index within a multiply phase
   logic signed [XW-1:0] den_ff, den_in, tn_ff, tn_in, un_ff, un_in;
   logic signed [PW-1:0] p_ff, p_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [PARAM_BITS-1:0] q_ff, q_in, t_ff, t_in;
   logic [QC-1:0] qc_ff, qc_in;
   logic          bv_ff, bv_in;
   logic [PARAM_BITS-1:0] bp_ff, bp_in;
   logic signed [CB-1:0] bx_ff, bx_in, by_ff, by_in;
   logic done_ff, done_in;

   logic signed [DW-1:0] rdx, rdy, sdx, sdy, dx, dy;
   assign rdx = DW'(ex) - DW'(ox);
   assign rdy = DW'(ey) - DW'(oy);
   assign sdx = DW'(bx) - DW'(ax);
   assign sdy = DW'(by) - DW'(ay);
   assign dx  = DW'(ax) - DW'(ox);
   assign dy  = DW'(ay) - DW'(oy);

   // multiplier operand select; the start is registered alongside the state change, so
   // operands follow the registered state, phase and t
   logic signed [MW-1:0] ma, mb_w;
   logic signed [DW-1:0] mb;
   logic                 mstart_in, mstart_ff, mdone;
   logic signed [MW+DW-1:0] mprod;
   always_comb begin
      ma = '0; mb = '0;
      if (state_ff == ST_PX || state_ff == ST_PY) begin
         ma = MW'($signed({1'b0, t_ff}));
         mb = (state_ff == ST_PX) ? rdx : rdy;
      end else begin
         unique case (ph_ff)
            3'd0: begin ma = MW'(rdx); mb = sdy; end
            3'd1: begin ma = MW'(rdy); mb = sdx; end
            3'd2: begin ma = MW'(dx);  mb = sdy; end
            3'd3: begin ma = MW'(dy);  mb = sdx; end
            3'd4: begin ma = MW'(dx);  mb = rdy; end
            default: begin ma = MW'(dy); mb = rdx; end
         endcase
      end
   end
   assign mb_w = MW'(mb);

   rpnh_serial_mul #(.AW(MW), .BW(DW)) u_mul (
      .clock, .reset, .start(mstart_ff), .a(ma), .b(mb), .done(mdone), .prod(mprod)
   );

   logic [MW+DW-1:0] shifted;
   logic signed [MW+DW:0] sum;
   logic signed [MW+DW:0] cmax, cmin;
   logic signed [CB-1:0]  coord;
   logic [XW-1:0] dabs;
   assign shifted = mprod >>> T_FRAC;
   assign dabs = XW'(den_ff);
   always_comb begin
      sum  = (MW+DW+1)'($signed(mprod) >>> T_FRAC) +
             (MW+DW+1)'((state_ff == ST_PX) ? ox : oy);
      cmax = (MW+DW+1)'({1'b0, {(CB-1){1'b1}}});
      cmin = -cmax - 1'b1;
      if (sum > cmax) coord = {1'b0, {(CB-1){1'b1}}};
      else if (sum < cmin) coord = {1'b1, {(CB-1){1'b0}}};
      else coord = CB'(sum);
   end

   logic [RW-1:0] rsh, dsub;
   logic [XW-1:0] tnu, unu;
   assign tnu = XW'(tn_ff);
   assign unu = XW'(un_ff);
   assign dsub = RW'(dabs);

   always_comb begin
      state_in = state_ff; ph_in = ph_ff; den_in = den_ff; tn_in = tn_ff;
      un_in = un_ff; p_in = p_ff; rem_in = rem_ff; q_in = q_ff; qc_in = qc_ff;
      t_in = t_ff; bv_in = bv_ff; bp_in = bp_ff; bx_in = bx_ff; by_in = by_ff;
      done_in = 1'b0; mstart_in = 1'b0; rsh = '0;
      if (ctl.clear_best) begin
         bv_in = 1'b0; bp_in = '1; bx_in = '0; by_in = '0;
      end
      unique case (state_ff)
         ST_IDLE: if (ctl.start) begin
            ph_in = '0; mstart_in = 1'b1; state_in = ST_M1;
         end
         ST_M1: if (mdone) begin
            p_in = PW'(mprod); ph_in = ph_ff + 1'b1; mstart_in = 1'b1; state_in = ST_M2;
         end
         ST_M2: if (mdone) begin
            unique case (ph_ff)
               3'd1: den_in = XW'(p_ff) - XW'(PW'(mprod));
               3'd3: tn_in  = XW'(p_ff) - XW'(PW'(mprod));
               default: un_in = XW'(p_ff) - XW'(PW'(mprod));
            endcase
            if (ph_ff == 3'd5) state_in = ST_CHK;
            else begin
               ph_in = ph_ff + 1'b1; mstart_in = 1'b1; state_in = ST_M1;
            end
         end
         ST_CHK: begin
            if (den_ff == '0) state_in = ST_DONE;
            else begin
               if (den_ff < 0) begin
                  den_in = -den_ff; tn_in = -tn_ff; un_in = -un_ff;
               end
               state_in = ST_DIV; qc_in = '0; rem_in = '0; q_in = '0;
               // validity checked on normalized values next cycle via sign
               ph_in = 3'd0;
            end
         end
         ST_DIV: begin
            if (ph_ff == 3'd0) begin
               ph_in = 3'd1;
               if (tn_ff <= 0 || un_ff < 0 || un_ff > den_ff) state_in = ST_DONE;
               else if (RW'(tnu) >= (RW'(dabs) << T_FRAC)) begin
                  t_in = '1; state_in = ST_PX; mstart_in = 1'b1;
               end else rem_in = RW'(tnu);
            end else begin
               // one quotient bit per cycle: integer bits compare against a shifted den, fraction
               // bits use long division on the shifted remainder
               rsh = {rem_ff[RW-2:0], 1'b0};
               if (qc_ff < QC'(T_FRAC)) begin
                  // integer bits: compare rem against den << (15-qc)
                  if (rem_ff >= (dsub << (QC'(T_FRAC - 1) - qc_ff))) begin
                     rem_in = rem_ff - (dsub << (QC'(T_FRAC - 1) - qc_ff));
                     q_in = {q_ff[PARAM_BITS-2:0], 1'b1};
                  end else q_in = {q_ff[PARAM_BITS-2:0], 1'b0};
               end else begin
                  if (rsh >= dsub) begin
                     rem_in = rsh - dsub; q_in = {q_ff[PARAM_BITS-2:0], 1'b1};
                  end else begin
                     rem_in = rsh; q_in = {q_ff[PARAM_BITS-2:0], 1'b0};
                  end
               end
               qc_in = qc_ff + 1'b1;
               if (qc_ff == QC'(PARAM_BITS - 1)) begin
                  t_in = q_in;
                  if (bv_ff && !(q_in < bp_ff)) state_in = ST_DONE;
                  else begin
                     state_in = ST_PX; mstart_in = 1'b1;
                  end
               end
            end
         end
         ST_PX: if (mdone) begin
            bx_in = coord; mstart_in = 1'b1; state_in = ST_PY;
         end
         ST_PY: if (mdone) begin
            by_in = coord; bv_in = 1'b1; bp_in = t_ff; state_in = ST_DONE;
         end
         ST_DONE: begin
            done_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_PX && mdone) begin
         // keep compare against the old best for the saturated path as well
         if (t_ff == '1 && bv_ff && !(t_ff < bp_ff)) begin
            state_in = ST_DONE; bx_in = bx_ff; mstart_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; done_ff <= 1'b0; bv_ff <= 1'b0; bp_ff <= '1;
         bx_ff <= '0; by_ff <= '0; ph_ff <= '0; qc_ff <= '0; mstart_ff <= 1'b0;
      end else begin
         state_ff <= state_in; done_ff <= done_in; bv_ff <= bv_in; bp_ff <= bp_in;
         bx_ff <= bx_in; by_ff <= by_in; ph_ff <= ph_in; qc_ff <= qc_in;
         mstart_ff <= mstart_in;
      end
      den_ff <= den_in; tn_ff <= tn_in; un_ff <= un_in; p_ff <= p_in;
      rem_ff <= rem_in; q_ff <= q_in; t_ff <= t_in;
   end

   assign sts.busy   = (state_ff != ST_IDLE);
   assign sts.done   = done_ff;
   assign best_valid = bv_ff;
   assign best_x     = bx_ff;
   assign best_y     = by_ff;
   logic unused;
   assign unused = ^{shifted, mb_w, unu};
endmodule
